[design/ppa_pkg.sv]
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types and constants of the playback phase advance core.
// ----------------------------------------------------------------------------
package ppa_pkg;

  // fixed field widths
  localparam int DELTA_W   = 16;
  localparam int SPEED_W   = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int PROD_W    = DELTA_W + SPEED_W;

  // fraction bits of delta_time
  localparam int DELTA_FRAC_BITS = 16;

  // parameter defaults
  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int SPEED_FRAC_BITS_DEF = 8;
  localparam int STEP_W_DEF =
    PROD_W - (DELTA_FRAC_BITS + SPEED_FRAC_BITS_DEF - PHASE_FRAC_BITS_DEF);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 1'd1;

  // loop mode codes, the fourth code behaves as clamp
  localparam logic [MODE_W-1:0] LOOP_CLAMP    = 2'd0;
  localparam logic [MODE_W-1:0] LOOP_REPEAT   = 2'd1;
  localparam logic [MODE_W-1:0] LOOP_PINGPONG = 2'd2;

  // control group handed to the step unit
  typedef struct packed {
    logic load;
    logic go;
    logic reverse;
    logic playing;
    logic new_reverse;
    logic new_playing;
  } ppa_ctl_t;

  // flags coming back from the step unit
  typedef struct packed {
    logic reverse;
    logic playing;
    logic advanced;
  } ppa_flags_t;

endpackage

[design/ppa_step_unit.sv]
// ----------------------------------------------------------------------------
// ppa_step_unit
// Next playback state: load, or advance by one step with clamp, wrap or
// ping-pong reflection at the ends.
// ----------------------------------------------------------------------------
module ppa_step_unit #(
  parameter int PHASE_FRAC_BITS = ppa_pkg::PHASE_FRAC_BITS_DEF,
  parameter int STEP_W          = ppa_pkg::STEP_W_DEF
) (
  input  logic [PHASE_FRAC_BITS:0]      phase_i,
  input  logic [PHASE_FRAC_BITS:0]      new_phase_i,
  input  logic [STEP_W-1:0]             step_i,
  input  logic [ppa_pkg::MODE_W-1:0]    mode_i,
  input  ppa_pkg::ppa_ctl_t             ctl_i,
  output logic [PHASE_FRAC_BITS:0]      phase_o,
  output ppa_pkg::ppa_flags_t           flags_o
);

  localparam int P_W   = PHASE_FRAC_BITS + 1;
  localparam int SUM_W = STEP_W + 2;
  localparam logic [P_W-1:0] ONE_P = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic [P_W:0]   TWO_P = {1'b1, {P_W{1'b0}}};
  localparam logic signed [SUM_W-1:0] ONE_S = {{(SUM_W-P_W){1'b0}}, ONE_P};

  always_comb begin : step_calc
    logic [P_W-1:0]                 ph_cur;
    logic signed [SUM_W-1:0]        ph_s;
    logic signed [SUM_W-1:0]        st_s;
    logic signed [SUM_W-1:0]        p;
    logic signed [SUM_W-1:0]        neg;
    logic signed [SUM_W-1:0]        q;
    logic [P_W-1:0]                 m;
    logic [PHASE_FRAC_BITS-1:0]     r;

    ph_cur = (phase_i > ONE_P) ? ONE_P : phase_i;
    ph_s   = {{(SUM_W-P_W){1'b0}}, ph_cur};
    st_s   = {2'b00, step_i};
    p      = ctl_i.reverse ? (ph_s - st_s) : (ph_s + st_s);
    neg    = -p;
    q      = p[SUM_W-1] ? neg : p;
    m      = q[P_W-1:0];
    r      = '0;

    phase_o          = ph_cur;
    flags_o.reverse  = ctl_i.reverse;
    flags_o.playing  = ctl_i.playing;
    flags_o.advanced = 1'b0;

    if (ctl_i.load) begin
      phase_o         = (new_phase_i > ONE_P) ? ONE_P : new_phase_i;
      flags_o.reverse = ctl_i.new_reverse;
      flags_o.playing = ctl_i.new_playing;
    end else if (ctl_i.playing && ctl_i.go) begin
      flags_o.advanced = 1'b1;
      unique case (mode_i)
        ppa_pkg::LOOP_REPEAT: begin
          if (p > ONE_S) begin
            r       = p[PHASE_FRAC_BITS-1:0];
            phase_o = (r == '0) ? ONE_P : {1'b0, r};
          end else if (p[SUM_W-1]) begin
            r       = neg[PHASE_FRAC_BITS-1:0];
            phase_o = (r == '0) ? '0 : (ONE_P - {1'b0, r});
          end else begin
            phase_o = p[P_W-1:0];
          end
        end
        ppa_pkg::LOOP_PINGPONG: begin
          // a negative result reflects at zero and turns forward first
          if (p[SUM_W-1]) begin
            flags_o.reverse = 1'b0;
          end
          if (q > ONE_S) begin
            // fold over a period of two
            flags_o.reverse = !((m != '0) && (m <= ONE_P));
            phase_o = (m <= ONE_P) ? m : P_W'(TWO_P - {1'b0, m});
          end else begin
            phase_o = q[P_W-1:0];
          end
        end
        default: begin
          if (p >= ONE_S) begin
            phase_o         = ONE_P;
            flags_o.playing = 1'b0;
          end else if (p[SUM_W-1] || (p == '0)) begin
            phase_o         = '0;
            flags_o.playing = 1'b0;
          end else begin
            phase_o = p[P_W-1:0];
          end
        end
      endcase
    end
  end

endmodule

[design/playback_phase_advance_core.sv]
// ----------------------------------------------------------------------------
// playback_phase_advance_core
// Normalized playback phase accumulator with clamp, repeat and ping-pong.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   request words: a tick (elapsed delta_time) or a load of phase,
//          direction and playing flag. valid/ready handshake.
//   out_*  one result word per request: phase, direction, playing flag and
//          whether the tick advanced. valid/ready handshake.
//   cfg_*  register writes: index 0 speed (Q8.8 at default), index 1 loop
//          mode. cfg_ready is always high; write only while idle.
// Timing:
//   one word per cycle sustained while out_ready is high. A word goes from
//   the input register to the result register and out_*. The step product
//   delta_time * speed is taken at the input register; the playback state
//   loop (add, wrap, reflect in the step unit) is combinational: words chain.
// Reset:
//   phase 0, forward, stopped; speed 1.0, clamp mode; both stages empty.
// Stall:
//   a stalled result holds in the output register; the input register still
//   takes one more word, then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module playback_phase_advance_core #(
  parameter int PHASE_FRAC_BITS = ppa_pkg::PHASE_FRAC_BITS_DEF,
  parameter int SPEED_FRAC_BITS = ppa_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [ppa_pkg::DELTA_W-1:0]     in_delta_time,
  input  logic [PHASE_FRAC_BITS:0]        in_new_phase,
  input  logic                            in_new_reverse,
  input  logic                            in_new_playing,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [PHASE_FRAC_BITS:0]        out_phase,
  output logic                            out_reverse,
  output logic                            out_playing,
  output logic                            out_advanced,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppa_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int P_W    = PHASE_FRAC_BITS + 1;
  localparam int SH     = ppa_pkg::DELTA_FRAC_BITS + SPEED_FRAC_BITS - PHASE_FRAC_BITS;
  localparam int STEP_W = ppa_pkg::PROD_W - SH;
  localparam logic [P_W-1:0] ONE_P = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic [ppa_pkg::SPEED_W-1:0] SPEED_RST =
    ppa_pkg::SPEED_W'(1) << SPEED_FRAC_BITS;

  // configuration
  logic [ppa_pkg::SPEED_W-1:0] speed_r;
  logic [ppa_pkg::MODE_W-1:0]  loop_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= SPEED_RST;
      loop_mode_r <= ppa_pkg::LOOP_CLAMP;
    end else if (cfg_valid) begin
      if (cfg_index == ppa_pkg::CFG_SPEED) begin
        speed_r <= cfg_wdata;
      end
      if (cfg_index == ppa_pkg::CFG_LOOP_MODE) begin
        loop_mode_r <= cfg_wdata[ppa_pkg::MODE_W-1:0];
      end
    end
  end

  // step size in phase units
  logic [ppa_pkg::PROD_W-1:0] prod;
  logic [STEP_W-1:0]          step;

  assign prod = ppa_pkg::PROD_W'(in_delta_time) * ppa_pkg::PROD_W'(speed_r);

  generate
    if (SH >= 0) begin : g_step_trunc
      assign step = STEP_W'(prod >> SH);
    end else begin : g_step_fill
      assign step = {prod, {(-SH){1'b0}}};
    end
  endgenerate

  // handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic out_load;
  logic s1_fire;
  logic in_fire;

  assign out_load = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input register
  logic              s1_load_r;
  logic              s1_go_r;
  logic [STEP_W-1:0] s1_step_r;
  logic [P_W-1:0]    s1_new_phase_r;
  logic              s1_new_rev_r;
  logic              s1_new_play_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_load_r      <= in_req_type;
      s1_go_r        <= (in_delta_time != '0) && (speed_r != '0);
      s1_step_r      <= step;
      s1_new_phase_r <= in_new_phase;
      s1_new_rev_r   <= in_new_reverse;
      s1_new_play_r  <= in_new_playing;
    end
  end

  // playback state
  logic [P_W-1:0]       phase_q_r;
  logic                 reverse_r;
  logic                 playing_r;
  logic [P_W-1:0]       phase_nxt;
  ppa_pkg::ppa_flags_t  flags_nxt;
  ppa_pkg::ppa_ctl_t    ctl;

  assign ctl.load        = s1_load_r;
  assign ctl.go          = s1_go_r;
  assign ctl.reverse     = reverse_r;
  assign ctl.playing     = playing_r;
  assign ctl.new_reverse = s1_new_rev_r;
  assign ctl.new_playing = s1_new_play_r;

  ppa_step_unit #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .STEP_W          (STEP_W)
  ) u_step (
    .phase_i     (phase_q_r),
    .new_phase_i (s1_new_phase_r),
    .step_i      (s1_step_r),
    .mode_i      (loop_mode_r),
    .ctl_i       (ctl),
    .phase_o     (phase_nxt),
    .flags_o     (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_q_r <= '0;
      reverse_r <= 1'b0;
      playing_r <= 1'b0;
    end else if (s1_fire) begin
      phase_q_r <= phase_nxt;
      reverse_r <= flags_nxt.reverse;
      playing_r <= flags_nxt.playing;
    end
  end

  // result register
  logic [P_W-1:0] out_phase_r;
  logic           out_reverse_r;
  logic           out_playing_r;
  logic           out_advanced_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_phase_r    <= phase_nxt;
      out_reverse_r  <= flags_nxt.reverse;
      out_playing_r  <= flags_nxt.playing;
      out_advanced_r <= flags_nxt.advanced;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_phase    = out_phase_r;
  assign out_reverse  = out_reverse_r;
  assign out_playing  = out_playing_r;
  assign out_advanced = out_advanced_r;

  // checks
  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_q_r <= ONE_P)
    else $error("playback phase above one");

  a_result_is_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (out_valid_r && (out_phase_r == phase_q_r)
                 && (out_reverse_r == reverse_r) && (out_playing_r == playing_r)))
    else $error("result word differs from playback state");

  a_load_not_advanced: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_load_r) |=> !out_advanced_r)
    else $error("load word flagged as advanced");

  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_load_r && !playing_r) |=> (!out_advanced_r && $stable(phase_q_r)))
    else $error("stopped tick moved the phase");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for playback_phase_advance_core. A queue of tick and
// load words feeds a bursty driver. A phase predictor written in this file
// follows every accepted word and register write, and a monitor checks each
// result word field by field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int     PH_BITS    = ppa_pkg::PHASE_FRAC_BITS_DEF;
  localparam int     PH_W       = PH_BITS + 1;
  localparam longint PH_ONE     = longint'(1) << PH_BITS;
  localparam int unsigned ONE_U = 32'd1 << PH_BITS;
  localparam int     STEP_SHIFT = ppa_pkg::DELTA_FRAC_BITS + ppa_pkg::SPEED_FRAC_BITS_DEF
                                  - ppa_pkg::PHASE_FRAC_BITS_DEF;
  localparam int     LIMIT      = 200000;
  localparam int     HOLD_LEN   = 400;

  // fourth mode code, behaves as clamp
  localparam logic [ppa_pkg::MODE_W-1:0] LOOP_AS_CLAMP = 2'd3;

  localparam int N_PLAN = 10;
  localparam int SPEED_PLAN [N_PLAN] = '{256, 256, 256, 65535, 65535, 1, 0, 40, 3000, 256};
  localparam logic [ppa_pkg::MODE_W-1:0] MODE_PLAN [N_PLAN] = '{
    ppa_pkg::LOOP_CLAMP, ppa_pkg::LOOP_REPEAT, ppa_pkg::LOOP_PINGPONG,
    ppa_pkg::LOOP_REPEAT, ppa_pkg::LOOP_PINGPONG, ppa_pkg::LOOP_CLAMP,
    ppa_pkg::LOOP_REPEAT, ppa_pkg::LOOP_PINGPONG, LOOP_AS_CLAMP, ppa_pkg::LOOP_CLAMP};

  typedef struct {
    logic                        load;
    logic [ppa_pkg::DELTA_W-1:0] delta;
    logic [PH_BITS:0]            new_phase;
    logic                        new_reverse;
    logic                        new_playing;
  } request_t;

  typedef struct {
    logic [PH_BITS:0] phase;
    logic             reverse;
    logic             playing;
    logic             advanced;
  } playback_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_req_type = 1'b0;
  logic [ppa_pkg::DELTA_W-1:0] in_delta_time = '0;
  logic [PH_BITS:0]            in_new_phase = '0;
  logic                        in_new_reverse = 1'b0;
  logic                        in_new_playing = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PH_BITS:0]   out_phase;
  logic               out_reverse;
  logic               out_playing;
  logic               out_advanced;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ppa_pkg::CFG_W-1:0]     cfg_wdata = '0;

  request_t  req_q [$];
  playback_t predicted_q [$];

  // predictor copy of the block
  logic [PH_BITS:0]             mdl_phase = '0;
  logic                         mdl_reverse = 1'b0;
  logic                         mdl_playing = 1'b0;
  logic [ppa_pkg::SPEED_W-1:0]  mdl_speed = 16'd256;
  logic [ppa_pkg::MODE_W-1:0]   mdl_mode = ppa_pkg::LOOP_CLAMP;

  int err_count = 0;
  int n_words = 0;
  int n_loads = 0;
  int n_adv = 0;
  int n_cfg = 0;
  int n_checked = 0;
  int cycle_count = 0;

  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int burst_left = 0;
  int gap_left = 0;

  playback_phase_advance_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_delta_time  (in_delta_time),
    .in_new_phase   (in_new_phase),
    .in_new_reverse (in_new_reverse),
    .in_new_playing (in_new_playing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_phase      (out_phase),
    .out_reverse    (out_reverse),
    .out_playing    (out_playing),
    .out_advanced   (out_advanced),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  // phase step: load, or advance then clamp, wrap or reflect
  function automatic playback_t advance_playback(request_t r);
    playback_t        res;
    longint unsigned  prod;
    longint           step_len;
    longint           p;
    longint           m;
    res.advanced = 1'b0;
    if (r.load) begin
      mdl_phase   = (longint'(r.new_phase) > PH_ONE) ? PH_ONE[PH_BITS:0] : r.new_phase;
      mdl_reverse = r.new_reverse;
      mdl_playing = r.new_playing;
    end else if (mdl_playing && mdl_speed != 0 && r.delta != 0) begin
      prod = 64'(r.delta);
      prod = prod * mdl_speed;
      step_len = (STEP_SHIFT >= 0) ? longint'(prod >> STEP_SHIFT)
                                   : longint'(prod << -STEP_SHIFT);
      p = mdl_reverse ? longint'(mdl_phase) - step_len : longint'(mdl_phase) + step_len;
      res.advanced = 1'b1;
      case (mdl_mode)
        ppa_pkg::LOOP_REPEAT: begin
          if (p > PH_ONE) begin
            m = p & (PH_ONE - 1);
            p = (m == 0) ? PH_ONE : m;
          end else if (p < 0) begin
            m = (-p) & (PH_ONE - 1);
            p = (m == 0) ? 0 : PH_ONE - m;
          end
        end
        ppa_pkg::LOOP_PINGPONG: begin
          if (p < 0) begin
            p = -p;
            mdl_reverse = 1'b0;
          end
          // fold over as many periods as the step spans
          if (p > PH_ONE) begin
            m = p & (2 * PH_ONE - 1);
            mdl_reverse = (m > 0 && m <= PH_ONE) ? 1'b0 : 1'b1;
            p = (m <= PH_ONE) ? m : 2 * PH_ONE - m;
          end
        end
        default: begin
          if (p >= PH_ONE) begin
            p = PH_ONE;
            mdl_playing = 1'b0;
          end else if (p <= 0) begin
            p = 0;
            mdl_playing = 1'b0;
          end
        end
      endcase
      mdl_phase = p[PH_BITS:0];
    end
    res.phase   = mdl_phase;
    res.reverse = mdl_reverse;
    res.playing = mdl_playing;
    return res;
  endfunction

  // driver: bursts of words with random gaps
  always @(posedge clk) begin : drv
    request_t nxt;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        in_valid       <= 1'b1;
        in_req_type    <= nxt.load;
        in_delta_time  <= nxt.delta;
        in_new_phase   <= nxt.new_phase;
        in_new_reverse <= nxt.new_reverse;
        in_new_playing <= nxt.new_playing;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_cycle  <= 0;
      hold_left <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_done != hold_asked) begin
        hold_done <= hold_done + 1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0:    out_ready <= 1'b1;
          2'd1:    out_ready <= ($urandom_range(0, 1) == 0);
          2'd2:    out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  // predictor and result check
  always @(posedge clk) begin : chk
    request_t  acc;
    playback_t want;
    if (!rst_n) begin
      mdl_phase   = '0;
      mdl_reverse = 1'b0;
      mdl_playing = 1'b0;
      mdl_speed   = 16'd256;
      mdl_mode    = ppa_pkg::LOOP_CLAMP;
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        if (cfg_index == ppa_pkg::CFG_SPEED) mdl_speed = cfg_wdata;
        else if (cfg_index == ppa_pkg::CFG_LOOP_MODE) mdl_mode = cfg_wdata[ppa_pkg::MODE_W-1:0];
      end
      if (in_valid && in_ready) begin
        acc.load        = in_req_type;
        acc.delta       = in_delta_time;
        acc.new_phase   = in_new_phase;
        acc.new_reverse = in_new_reverse;
        acc.new_playing = in_new_playing;
        want = advance_playback(acc);
        predicted_q.push_back(want);
        n_words++;
        if (acc.load) n_loads++;
        if (want.advanced) n_adv++;
      end
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          $error("unexpected result word: phase %0d", out_phase);
          err_count++;
        end else begin
          want = predicted_q.pop_front();
          n_checked++;
          if (out_phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, out_phase);
            err_count++;
          end
          if (out_reverse !== want.reverse) begin
            $error("reverse: expected %0d, got %0d", want.reverse, out_reverse);
            err_count++;
          end
          if (out_playing !== want.playing) begin
            $error("playing: expected %0d, got %0d", want.playing, out_playing);
            err_count++;
          end
          if (out_advanced !== want.advanced) begin
            $error("advanced: expected %0d, got %0d", want.advanced, out_advanced);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_q.size());
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic add_tick(input logic [ppa_pkg::DELTA_W-1:0] dt);
    request_t r;
    r.load = 1'b0;
    r.delta = dt;
    r.new_phase = '0;
    r.new_reverse = 1'b0;
    r.new_playing = 1'b0;
    req_q.push_back(r);
  endtask

  task automatic add_load(input logic [PH_BITS:0] ph, input logic rev, input logic play);
    request_t r;
    r.load = 1'b1;
    r.delta = '0;
    r.new_phase = ph;
    r.new_reverse = rev;
    r.new_playing = play;
    req_q.push_back(r);
  endtask

  task automatic fill_random(input int n);
    request_t r;
    for (int i = 0; i < n; i++) begin
      r.load = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       r.delta = '0;
        1:       r.delta = '1;
        2, 3:    r.delta = ppa_pkg::DELTA_W'($urandom_range(1, 255));
        4, 5:    r.delta = ppa_pkg::DELTA_W'($urandom_range(1, 4095));
        default: r.delta = ppa_pkg::DELTA_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       r.new_phase = '0;
        1:       r.new_phase = PH_ONE[PH_BITS:0];
        2:       r.new_phase = PH_W'($urandom_range(ONE_U + 1, 2 * ONE_U - 1));
        3:       r.new_phase = PH_W'($urandom_range(0, 255));
        4:       r.new_phase = PH_W'(ONE_U - $urandom_range(0, 255));
        default: r.new_phase = PH_W'($urandom_range(0, ONE_U));
      endcase
      r.new_reverse = 1'($urandom_range(0, 1));
      r.new_playing = ($urandom_range(0, 6) != 0);
      req_q.push_back(r);
    end
  endtask

  task automatic write_reg(input logic [ppa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppa_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // sender stays quiet until every predicted result is back
  task automatic wait_drained();
    do @(posedge clk); while (req_q.size() != 0 || in_valid || predicted_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    logic [ppa_pkg::SPEED_W-1:0] spd;
    logic [ppa_pkg::MODE_W-1:0]  mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: speed 1.0, clamp
    add_tick(16'hFFFF);                   // stopped, no advance
    add_load('1, 1'b1, 1'b1);             // above 1.0 saturates
    add_tick(16'h0001);
    add_load(PH_ONE[PH_BITS:0], 1'b0, 1'b1);
    add_tick(16'h0100);                   // hits the top, stops
    add_load('0, 1'b1, 1'b1);
    add_tick(16'h0000);                   // zero delta
    add_tick(16'hFFFF);                   // hits the bottom, stops
    wait_drained();

    // step truncated to zero
    write_reg(ppa_pkg::CFG_SPEED, 16'd1);
    add_load(PH_ONE[PH_BITS:0], 1'b0, 1'b1);
    add_tick(16'd5);                      // sitting at the end still stops
    add_load(17'd100, 1'b0, 1'b1);
    add_tick(16'd255);
    wait_drained();

    write_reg(ppa_pkg::CFG_SPEED, 16'd0);
    write_reg(ppa_pkg::CFG_LOOP_MODE, LOOP_AS_CLAMP);
    add_load(17'd30000, 1'b0, 1'b1);
    add_tick(16'hFFFF);                   // zero speed
    wait_drained();

    // repeat ends: exact 1.0 and exact 0 stay put
    write_reg(ppa_pkg::CFG_SPEED, 16'd512);
    write_reg(ppa_pkg::CFG_LOOP_MODE, ppa_pkg::LOOP_REPEAT);
    add_load(PH_W'(PH_ONE - 2), 1'b0, 1'b1);
    add_tick(16'd1);
    add_load(17'd2, 1'b1, 1'b1);
    add_tick(16'd1);
    add_load(PH_ONE[PH_BITS:0], 1'b0, 1'b1);
    add_tick(16'd32768);                  // lands on 2.0
    add_load('0, 1'b1, 1'b1);
    add_tick(16'd32768);                  // lands on -1.0
    wait_drained();

    // ping-pong ends and reflection
    write_reg(ppa_pkg::CFG_LOOP_MODE, ppa_pkg::LOOP_PINGPONG);
    add_load(PH_W'(PH_ONE / 2), 1'b1, 1'b1);
    add_tick(16'd16384);                  // exact 0 keeps direction
    add_load(17'd100, 1'b1, 1'b1);
    add_tick(16'd16384);                  // below 0 reflects
    add_load(PH_ONE[PH_BITS:0], 1'b0, 1'b1);
    add_tick(16'd32768);                  // lands on 2.0
    wait_drained();

    for (int ph = 0; ph < N_PLAN; ph++) begin
      spd  = (ph == N_PLAN - 1) ? ppa_pkg::SPEED_W'($urandom_range(1, 65535))
                                : ppa_pkg::SPEED_W'(SPEED_PLAN[ph]);
      mode = (ph == N_PLAN - 1) ? ppa_pkg::MODE_W'($urandom_range(0, 3)) : MODE_PLAN[ph];
      write_reg(ppa_pkg::CFG_SPEED, spd);
      write_reg(ppa_pkg::CFG_LOOP_MODE, mode);
      fill_random(128);
      // long receiver hold-off while words keep coming
      if (ph == 2) hold_asked <= hold_asked + 1;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d words (%0d loads, %0d advancing ticks) with %0d register writes",
             n_words, n_loads, n_adv, n_cfg);
    $display("%0d results checked, %0d mismatches", n_checked, err_count);
    if (err_count == 0 && predicted_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/ppa_pkg.sv
design/ppa_step_unit.sv
design/playback_phase_advance_core.sv
verif/tb_top.sv
